// ----- hdl/bmprle4_pkg.sv -----
// ----------------------------------------------------------------------------
// bmprle4_pkg
// Shared types, constants and helper functions of the BMP RLE4 span decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bmprle4_pkg;

  localparam int CfgWidth  = 12;
  localparam int XWidth    = 13;
  localparam int YWidth    = 14;
  localparam int LenWidth  = 8;
  localparam int ColWidth  = 4;
  localparam int IdxWidth  = 2;

  // register indexes on the configuration port
  localparam logic [IdxWidth-1:0] REG_ORIGIN_LEFT  = 2'd0;
  localparam logic [IdxWidth-1:0] REG_ORIGIN_TOP   = 2'd1;
  localparam logic [IdxWidth-1:0] REG_IMAGE_WIDTH  = 2'd2;
  localparam logic [IdxWidth-1:0] REG_IMAGE_HEIGHT = 2'd3;

  localparam logic [CfgWidth-1:0] ORIGIN_LEFT_RST  = 12'd0;
  localparam logic [CfgWidth-1:0] ORIGIN_TOP_RST   = 12'd0;
  localparam logic [CfgWidth-1:0] IMAGE_WIDTH_RST  = 12'd640;
  localparam logic [CfgWidth-1:0] IMAGE_HEIGHT_RST = 12'd480;

  localparam logic [XWidth-1:0]          X_MAX = 13'd8191;
  localparam logic signed [YWidth:0]     Y_MIN = -15'sd4096;

  // escape codes following a zero count byte
  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_COLOR,
    PH_ESC,
    PH_ABS,
    PH_PAD,
    PH_DX,
    PH_DY,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [CfgWidth-1:0] origin_left;
    logic [CfgWidth-1:0] origin_top;
    logic [CfgWidth-1:0] image_width;
    logic [CfgWidth-1:0] image_height;
  } cfg_t;

  typedef struct packed {
    logic [XWidth-1:0]        span_x;
    logic signed [YWidth-1:0] span_y;
    logic [LenWidth-1:0]      span_length;
    logic [ColWidth-1:0]      even_color;
    logic [ColWidth-1:0]      odd_color;
    logic                     image_done;
  } span_t;

  // handshake between the input register and the decode core
  typedef struct packed {
    logic       valid;
    logic [7:0] code_byte;
    logic       image_start;
  } item_t;

  // pixels of a run that fit between the cursor and the right clip edge
  function automatic logic [LenWidth-1:0] clip_len(input logic [LenWidth-1:0] n,
                                                   input logic [XWidth-1:0] cx,
                                                   input logic [XWidth-1:0] edge_x);
    logic [XWidth-1:0] room;
    room = edge_x - cx;
    if (cx >= edge_x) begin
      return '0;
    end else if (room < {{(XWidth-LenWidth){1'b0}}, n}) begin
      return room[LenWidth-1:0];
    end else begin
      return n;
    end
  endfunction

  function automatic logic [XWidth-1:0] sat_add_x(input logic [XWidth-1:0] cx,
                                                  input logic [LenWidth-1:0] n);
    logic [XWidth:0] sum;
    sum = {1'b0, cx} + {{(XWidth+1-LenWidth){1'b0}}, n};
    return sum[XWidth] ? X_MAX : sum[XWidth-1:0];
  endfunction

  function automatic logic signed [YWidth-1:0] sat_sub_y(input logic signed [YWidth-1:0] cy,
                                                         input logic [LenWidth-1:0] n);
    logic signed [YWidth:0] diff;
    diff = $signed({cy[YWidth-1], cy}) - $signed({{(YWidth+1-LenWidth){1'b0}}, n});
    return (diff < Y_MIN) ? Y_MIN[YWidth-1:0] : diff[YWidth-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/bmp_rle4_span_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// bmp_rle4_span_decoder_unit
// BMP RLE4 stream decoder that turns compressed bytes into pixel spans.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one compressed byte per transfer in s_tdata; s_tuser marks
//   the first byte of an image and restarts the cursor at the bottom-left
//   pixel (origin_left, origin_top + image_height - 1).
//   Master channel: zero or one span per byte. m_tlast flags the end-of-image
//   marker (length 0); later bytes are dropped until the next s_tuser.
//   Config port: cfg_we/cfg_index/cfg_data write origin_left, origin_top,
//   image_width, image_height (indexes 0..3). Write only while idle.
//   Path: a byte goes from the input register through the decode logic;
//   its span is registered in the result register that drives m_tdata.
//   Throughput: one byte per cycle while no span waits on m_tready; the
//   phase and cursor registers update on each byte taken.
//   Stall: while a span waits on m_tready, the decoder holds; one further
//   byte is buffered in the input register, then s_tready drops.
//   Reset: registers return to 0, 0, 640, 480 and the decoder expects a
//   run count at column 0, row 479.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_rle4_span_decoder_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [7:0]                       s_tdata,   // [7:0] code_byte
  input  wire logic                             s_tuser,   // [0] image_start
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // [12:0] span_x, [26:13] span_y, [34:27] span_length,
  // [38:35] even_color, [42:39] odd_color, [47:43] zero
  output logic [47:0]                           m_tdata,
  output logic                                  m_tlast,   // image_done
  input  wire logic                             cfg_we,
  input  wire logic [bmprle4_pkg::IdxWidth-1:0] cfg_index,
  input  wire logic [bmprle4_pkg::CfgWidth-1:0] cfg_data
);
  import bmprle4_pkg::*;

  cfg_t  cfg;
  item_t item;
  span_t res;
  logic  take, res_valid, out_busy;

  bmprle4_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bmprle4_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .take     (take),
    .item     (item)
  );

  bmprle4_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item      (item),
    .out_busy  (out_busy),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  bmprle4_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (take && res_valid),
    .res      (res),
    .busy     (out_busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

// ----- hdl/bmprle4_cfg.sv -----
// ----------------------------------------------------------------------------
// bmprle4_cfg
// Configuration register file: origin, width and height of the image.
// ----------------------------------------------------------------------------
`default_nettype none

module bmprle4_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [bmprle4_pkg::IdxWidth-1:0]   cfg_index,
  input  wire logic [bmprle4_pkg::CfgWidth-1:0]   cfg_data,
  output bmprle4_pkg::cfg_t                       cfg
);
  import bmprle4_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_left  <= ORIGIN_LEFT_RST;
      cfg.origin_top   <= ORIGIN_TOP_RST;
      cfg.image_width  <= IMAGE_WIDTH_RST;
      cfg.image_height <= IMAGE_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_LEFT:  cfg.origin_left  <= cfg_data;
        REG_ORIGIN_TOP:   cfg.origin_top   <= cfg_data;
        REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/bmprle4_in_stage.sv -----
// ----------------------------------------------------------------------------
// bmprle4_in_stage
// Input register: holds one code byte until the decode core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bmprle4_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,
  input  wire logic          s_tuser,
  input  wire logic          take,
  output bmprle4_pkg::item_t item
);
  import bmprle4_pkg::*;

  logic valid;
  logic [7:0] code_byte;
  logic image_start;

  assign s_tready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      code_byte   <= s_tdata;
      image_start <= s_tuser;
    end
  end

  assign item = '{valid: valid, code_byte: code_byte, image_start: image_start};

endmodule

`default_nettype wire

// ----- hdl/bmprle4_core.sv -----
// ----------------------------------------------------------------------------
// bmprle4_core
// Decode state machine: phase, cursor, run counters; one span per byte max.
// ----------------------------------------------------------------------------
`default_nettype none

module bmprle4_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire bmprle4_pkg::cfg_t  cfg,
  input  wire bmprle4_pkg::item_t item,
  input  wire logic          out_busy,
  output logic               take,
  output logic               res_valid,
  output bmprle4_pkg::span_t res
);
  import bmprle4_pkg::*;

  phase_t                    phase, phase_next;
  logic [XWidth-1:0]         cursor_x, cursor_x_next;
  logic signed [YWidth-1:0]  cursor_y, cursor_y_next;
  logic [LenWidth-1:0]       pending_run, pending_run_next;
  logic [LenWidth-1:0]       visible_left, visible_left_next;
  logic [LenWidth-1:0]       bytes_left, bytes_left_next;
  logic                      byte_parity, byte_parity_next;

  // state as seen by this byte, after an optional restart
  phase_t                    eff_phase;
  logic [XWidth-1:0]         eff_x;
  logic signed [YWidth-1:0]  eff_y;
  logic [LenWidth-1:0]       eff_pending, eff_visible, eff_bytes;
  logic                      eff_parity;

  logic [XWidth-1:0]         edge_x;
  logic signed [YWidth-1:0]  start_y;
  logic [LenWidth-1:0]       run_len, abs_visible, bytes_dec;
  logic [3:0]                hi, lo;
  logic [LenWidth-1:0]       emit_len;

  localparam logic [XWidth-1:0]         X_RST = {1'b0, ORIGIN_LEFT_RST};
  localparam logic signed [YWidth-1:0]  Y_RST = YWidth'({2'b00, ORIGIN_TOP_RST})
                                              + YWidth'({2'b00, IMAGE_HEIGHT_RST})
                                              - YWidth'(1);

  assign take = item.valid && !out_busy;

  assign hi      = item.code_byte[7:4];
  assign lo      = item.code_byte[3:0];
  assign edge_x  = {1'b0, cfg.origin_left} + {1'b0, cfg.image_width};
  assign start_y = $signed({2'b00, cfg.origin_top}) + $signed({2'b00, cfg.image_height})
                 - $signed(YWidth'(1));

  always_comb begin
    if (item.image_start) begin
      eff_phase   = PH_COUNT;
      eff_x       = {1'b0, cfg.origin_left};
      eff_y       = start_y;
      eff_pending = '0;
      eff_visible = '0;
      eff_bytes   = '0;
      eff_parity  = 1'b0;
    end else begin
      eff_phase   = phase;
      eff_x       = cursor_x;
      eff_y       = cursor_y;
      eff_pending = pending_run;
      eff_visible = visible_left;
      eff_bytes   = bytes_left;
      eff_parity  = byte_parity;
    end
  end

  assign run_len     = clip_len(eff_pending, eff_x, edge_x);
  assign abs_visible = clip_len(item.code_byte, eff_x, edge_x);
  assign bytes_dec   = (eff_bytes != '0) ? eff_bytes - LenWidth'(1) : eff_bytes;

  // next phase
  always_comb begin
    phase_next = eff_phase;
    unique case (eff_phase)
      PH_COUNT: phase_next = (item.code_byte != '0) ? PH_COLOR : PH_ESC;
      PH_COLOR: phase_next = PH_COUNT;
      PH_ESC: begin
        priority case (item.code_byte)
          ESC_EOL:   phase_next = PH_COUNT;
          ESC_EOB:   phase_next = PH_DONE;
          ESC_DELTA: phase_next = PH_DX;
          default:   phase_next = PH_ABS;
        endcase
      end
      PH_ABS: begin
        // pad byte follows when the absolute run ends on an odd byte count
        if (bytes_dec == '0) phase_next = !eff_parity ? PH_PAD : PH_COUNT;
      end
      PH_PAD:  phase_next = PH_COUNT;
      PH_DX:   phase_next = PH_DY;
      PH_DY:   phase_next = PH_COUNT;
      PH_DONE: phase_next = PH_DONE;
      default: phase_next = PH_DONE;
    endcase
  end

  // datapath and result
  always_comb begin
    cursor_x_next     = eff_x;
    cursor_y_next     = eff_y;
    pending_run_next  = eff_pending;
    visible_left_next = eff_visible;
    bytes_left_next   = eff_bytes;
    byte_parity_next  = (eff_phase == PH_DONE) ? eff_parity : !eff_parity;
    res_valid         = 1'b0;
    res.span_x        = eff_x;
    res.span_y        = eff_y;
    res.span_length   = '0;
    res.even_color    = '0;
    res.odd_color     = '0;
    res.image_done    = 1'b0;
    emit_len          = '0;
    unique case (eff_phase)
      PH_COUNT: begin
        if (item.code_byte != '0) pending_run_next = item.code_byte;
      end
      PH_COLOR: begin
        res_valid        = 1'b1;
        emit_len         = run_len;
        res.span_length  = run_len;
        res.even_color   = (run_len >= LenWidth'(1)) ? hi : '0;
        res.odd_color    = (run_len >= LenWidth'(2)) ? lo : '0;
        cursor_x_next    = sat_add_x(eff_x, run_len);
        pending_run_next = '0;
      end
      PH_ESC: begin
        priority case (item.code_byte)
          ESC_EOL: begin
            cursor_x_next = {1'b0, cfg.origin_left};
            cursor_y_next = sat_sub_y(eff_y, LenWidth'(1));
          end
          ESC_EOB: begin
            res_valid      = 1'b1;
            res.image_done = 1'b1;
          end
          ESC_DELTA: ;
          default: begin
            visible_left_next = abs_visible;
            bytes_left_next   = LenWidth'(({1'b0, item.code_byte} + 9'd1) >> 1);
          end
        endcase
      end
      PH_ABS: begin
        if (eff_visible >= LenWidth'(2)) begin
          res_valid         = 1'b1;
          emit_len          = LenWidth'(2);
          res.span_length   = LenWidth'(2);
          res.even_color    = hi;
          res.odd_color     = lo;
          visible_left_next = eff_visible - LenWidth'(2);
        end else if (eff_visible == LenWidth'(1)) begin
          res_valid         = 1'b1;
          emit_len          = LenWidth'(1);
          res.span_length   = LenWidth'(1);
          res.even_color    = hi;
          visible_left_next = '0;
        end
        cursor_x_next   = sat_add_x(eff_x, emit_len);
        bytes_left_next = bytes_dec;
      end
      PH_PAD: ;
      PH_DX:   cursor_x_next = sat_add_x(eff_x, item.code_byte);
      PH_DY:   cursor_y_next = sat_sub_y(eff_y, item.code_byte);
      PH_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_COUNT;
      cursor_x     <= X_RST;
      cursor_y     <= Y_RST;
      pending_run  <= '0;
      visible_left <= '0;
      bytes_left   <= '0;
      byte_parity  <= 1'b0;
    end else if (take) begin
      phase        <= phase_next;
      cursor_x     <= cursor_x_next;
      cursor_y     <= cursor_y_next;
      pending_run  <= pending_run_next;
      visible_left <= visible_left_next;
      bytes_left   <= bytes_left_next;
      byte_parity  <= byte_parity_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/bmprle4_out_stage.sv -----
// ----------------------------------------------------------------------------
// bmprle4_out_stage
// Result register: holds one span until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bmprle4_out_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire bmprle4_pkg::span_t res,
  output logic               busy,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [47:0]        m_tdata,
  output logic               m_tlast
);
  import bmprle4_pkg::*;

  logic  valid;
  span_t span;

  assign busy     = valid && !m_tready;
  assign m_tvalid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (m_tready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) span <= res;
  end

  assign m_tdata = {5'b0, span.odd_color, span.even_color, span.span_length,
                    span.span_y, span.span_x};
  assign m_tlast = span.image_done;

endmodule

`default_nettype wire
